>>> hw/rtl/nbgf_pkg.sv
// ---------------------------------------------------------------------------
// nbgf_pkg - shared types and constants of the gravity force block
// Body record, queue entry, result record, register indexes and sequencer
// states used by the front end, the back end and the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package nbgf_pkg;

  localparam int MAX_BODIES_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;
  localparam int CNT_W          = 7;    // holds a body count of up to 127
  localparam int POS_W          = 30;
  localparam int MASS_W         = 32;
  localparam int FORCE_W        = 48;
  localparam int IDX_W          = 6;
  localparam int R2_W           = 62;   // squared separation
  localparam int ROOT_W         = 31;
  localparam int DIV_NUM_W      = 103;  // widest dividend, t * |d|
  localparam int DIV_DEN_W      = 62;   // widest divisor, r * r
  localparam int DIV_CNT_W      = 7;
  localparam int T_W            = 72;   // (G * mi * mj) >> 24, and t
  localparam int TERM_W         = 56;
  localparam int SUM_W          = 64;

  typedef enum logic [0:0] {
    REG_GRAVITY = 1'b0,
    REG_AXES    = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [MASS_W-1:0] mass;
    logic [POS_W-1:0]  z;
    logic [POS_W-1:0]  y;
    logic [POS_W-1:0]  x;
  } body_t;

  localparam int BODY_W = $bits(body_t);

  typedef struct packed {
    body_t            body;
    logic             keep;   // written to the store
    logic             last;   // closes the set
    logic             ovf;    // some load of this set was dropped
    logic [CNT_W-1:0] n;      // bodies held after this beat
  } job_t;

  localparam int JOB_W = $bits(job_t);

  typedef struct packed {
    logic               last;
    logic               ovf;
    logic               sat;
    logic [FORCE_W-1:0] fz;
    logic [FORCE_W-1:0] fy;
    logic [FORCE_W-1:0] fx;
    logic [IDX_W-1:0]   idx;
  } result_t;

  typedef struct packed {
    logic [FORCE_W-1:0] v;
    logic               clip;
  } clamp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_POP, S_RDI, S_GM, S_RDJ, S_DIFF, S_SQ, S_CHK, S_SQRT, S_RR,
    S_S0, S_S1, S_S2, S_TSTART, S_TDIV, S_AX, S_PMUL, S_MSTART, S_MDIV, S_EMIT
  } bstate_t;

  // Clamp a 64-bit signed sum into the 48-bit signed output range.
  function automatic clamp_t clamp48(input logic [SUM_W-1:0] s);
    clamp_t res;
    res.clip = 1'b0;
    res.v    = s[FORCE_W-1:0];
    if ($signed(s) > $signed({{(SUM_W-FORCE_W+1){1'b0}}, {(FORCE_W-1){1'b1}}})) begin
      res.v    = {1'b0, {(FORCE_W-1){1'b1}}};
      res.clip = 1'b1;
    end else if ($signed(s) < $signed({{(SUM_W-FORCE_W+1){1'b1}}, {(FORCE_W-1){1'b0}}})) begin
      res.v    = {1'b1, {(FORCE_W-1){1'b0}}};
      res.clip = 1'b1;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/nbgf_ram.sv
// ---------------------------------------------------------------------------
// nbgf_ram - generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module nbgf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/nbgf_fifo.sv
// ---------------------------------------------------------------------------
// nbgf_fifo - short flop-based queue
// Holds load beats between the front end and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module nbgf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_r, rd_r;
  logic [CW-1:0]    cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) begin
        wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(push && !full) - CW'(pop && !empty);
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/nbgf_front.sv
// ---------------------------------------------------------------------------
// nbgf_front - load classifier
// Counts the bodies of a set, marks beats beyond capacity as dropped and
// queues every beat for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module nbgf_front #(
  parameter int MAX_BODIES = nbgf_pkg::MAX_BODIES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 three_axes,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire nbgf_pkg::body_t      in_body,
  input  wire logic                 in_last,
  output logic                      q_push,
  output nbgf_pkg::job_t            q_job,
  input  wire logic                 q_full
);

  import nbgf_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             keep, accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;
  assign keep      = (count_r < CNT_W'(MAX_BODIES));

  always_comb begin
    q_job        = '0;
    q_job.body   = in_body;
    if (!three_axes) begin
      q_job.body.z = '0;
    end
    q_job.keep   = keep;
    q_job.last   = in_last;
    q_job.ovf    = ovf_r || !keep;
    q_job.n      = count_r + CNT_W'(keep);
    q_push       = accept;
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (accept) begin
      if (in_last) begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end else begin
        count_nxt = count_r + CNT_W'(keep);
        ovf_nxt   = ovf_r || !keep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/nbgf_sqrt.sv
// ---------------------------------------------------------------------------
// nbgf_sqrt - iterative integer square root
// Floor root of a 62-bit value, one result bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module nbgf_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [nbgf_pkg::R2_W-1:0]   val,
  output logic                             done_r,
  output logic      [nbgf_pkg::ROOT_W-1:0] root_r
);

  import nbgf_pkg::*;

  localparam int REM_W = ROOT_W + 3;

  logic [R2_W-1:0]  val_r;
  logic [REM_W-1:0] rem_r, rem_sh, trial;
  logic [4:0]       cnt_r;
  logic             busy_r;
  logic             fits;

  assign rem_sh = {rem_r[REM_W-3:0], val_r[R2_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= val;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      val_r  <= {val_r[R2_W-3:0], 2'b00};
      rem_r  <= fits ? rem_sh - trial : rem_sh;
      root_r <= {root_r[ROOT_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(ROOT_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/nbgf_div.sv
// ---------------------------------------------------------------------------
// nbgf_div - shared restoring divider
// Unsigned division, one quotient bit per cycle; the dividend comes
// left-aligned and the caller gives the number of quotient bits wanted.
// ---------------------------------------------------------------------------
`default_nettype none

module nbgf_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [nbgf_pkg::DIV_NUM_W-1:0] num,
  input  wire logic [nbgf_pkg::DIV_DEN_W-1:0] den,
  input  wire logic [nbgf_pkg::DIV_CNT_W-1:0] iters,
  output logic                                done_r,
  output logic      [nbgf_pkg::DIV_NUM_W-1:0] quo_r
);

  import nbgf_pkg::*;

  logic [DIV_NUM_W-1:0] num_r;
  logic [DIV_DEN_W-1:0] den_r, rem_r;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 fits;

  assign rem_sh = {rem_r, num_r[DIV_NUM_W-1]};
  assign fits   = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[DIV_NUM_W-2:0], 1'b0};
      rem_r <= fits ? DIV_DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DIV_DEN_W-1:0];
      quo_r <= {quo_r[DIV_NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= iters - 1'b1;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/nbgf_back.sv
// ---------------------------------------------------------------------------
// nbgf_back - force sequencer
// Writes queued bodies to the store and, at the end of a set, walks every
// pair that is not coincident through the shared root and divide units,
// then emits one net force per body through an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module nbgf_back #(
  parameter int MAX_BODIES = nbgf_pkg::MAX_BODIES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [31:0]                  gravity,
  input  wire logic                         three_axes,
  input  wire logic                         q_empty,
  input  wire nbgf_pkg::job_t               q_job,
  output logic                              q_pop,
  output logic                              out_valid_r,
  input  wire logic                         out_ready,
  output nbgf_pkg::result_t                 out_res_r
);

  import nbgf_pkg::*;

  localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;

  bstate_t state_r, state_nxt;

  // Store
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  body_t           ram_rdata;

  // Sequencer registers
  logic [CNT_W-1:0]     n_r, i_r, j_r;
  logic                 set_ovf_r;
  logic [POS_W-1:0]     xi_r, yi_r, zi_r;
  logic [63:0]          gm_r;
  logic [MASS_W-1:0]    mj_r;
  logic [ROOT_W-1:0]    ad_r [3];
  logic                 neg_r [3];
  logic [1:0]           ax_r, k_r;
  logic [R2_W-1:0]      r2_r;
  logic [ROOT_W-1:0]    r_r;
  logic [DIV_DEN_W-1:0] rr_r;
  logic [63:0]          plo_r, phi_r;
  logic [T_W-1:0]       s_r, t_r;
  logic [DIV_NUM_W-1:0] p_r;
  logic [SUM_W-1:0]     sum_r [3];
  logic                 clip_r;

  // Shared units
  logic                 sq_start, sq_done;
  logic [ROOT_W-1:0]    sq_root;
  logic                 dv_start, dv_done;
  logic [DIV_NUM_W-1:0] dv_num, dv_quo;
  logic [DIV_DEN_W-1:0] dv_den;
  logic [DIV_CNT_W-1:0] dv_iters;

  logic                 emit_ok, last_i;
  logic [30:0]          dx, dy, dz;
  logic [23:0]          chunk;
  logic [54:0]          cprod;
  logic [DIV_NUM_W-1:0] cterm;
  logic                 mclip;
  logic [TERM_W-1:0]    mag;
  logic [SUM_W-1:0]     term;
  clamp_t               cx, cy, cz;

  nbgf_ram #(.WIDTH(BODY_W), .DEPTH(MAX_BODIES)) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (q_job.body),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  nbgf_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sq_start),
    .val    (r2_r),
    .done_r (sq_done),
    .root_r (sq_root)
  );

  nbgf_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (dv_start),
    .num    (dv_num),
    .den    (dv_den),
    .iters  (dv_iters),
    .done_r (dv_done),
    .quo_r  (dv_quo)
  );

  assign emit_ok = !out_valid_r || out_ready;
  assign last_i  = ((i_r + 1'b1) == n_r);

  // Separations from the body just read back
  assign dx = 31'($signed({ram_rdata.x[POS_W-1], ram_rdata.x}) -
                  $signed({xi_r[POS_W-1], xi_r}));
  assign dy = 31'($signed({ram_rdata.y[POS_W-1], ram_rdata.y}) -
                  $signed({yi_r[POS_W-1], yi_r}));
  assign dz = three_axes ? 31'($signed({ram_rdata.z[POS_W-1], ram_rdata.z}) -
                               $signed({zi_r[POS_W-1], zi_r})) : '0;

  // One 24-bit slice of t times |d|, placed at its weight
  always_comb begin
    case (k_r)
      2'd0:    chunk = t_r[23:0];
      2'd1:    chunk = t_r[47:24];
      default: chunk = t_r[71:48];
    endcase
    cprod = 55'(chunk * ad_r[ax_r]);
    case (k_r)
      2'd0:    cterm = DIV_NUM_W'(cprod);
      2'd1:    cterm = DIV_NUM_W'(cprod) << 24;
      default: cterm = DIV_NUM_W'(cprod) << 48;
    endcase
  end

  assign mclip = |dv_quo[DIV_NUM_W-1:TERM_W];
  assign mag   = mclip ? {TERM_W{1'b1}} : dv_quo[TERM_W-1:0];
  assign term  = neg_r[ax_r] ? SUM_W'(-{8'b0, mag}) : {8'b0, mag};

  assign cx = clamp48(sum_r[0]);
  assign cy = clamp48(sum_r[1]);
  assign cz = clamp48(sum_r[2]);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (!q_empty) state_nxt = S_POP;
      S_POP:    state_nxt = q_job.last ? S_RDI : S_IDLE;
      S_RDI:    state_nxt = S_GM;
      S_GM:     state_nxt = S_RDJ;
      S_RDJ: begin
        if (j_r == n_r) begin
          state_nxt = S_EMIT;
        end else if (j_r != i_r) begin
          state_nxt = S_DIFF;
        end
      end
      S_DIFF:   state_nxt = S_SQ;
      S_SQ:     if (ax_r == 2'd2) state_nxt = S_CHK;
      S_CHK:    state_nxt = (r2_r == '0) ? S_RDJ : S_SQRT;
      S_SQRT:   if (sq_done) state_nxt = S_RR;
      S_RR:     state_nxt = S_S0;
      S_S0:     state_nxt = S_S1;
      S_S1:     state_nxt = S_S2;
      S_S2:     state_nxt = S_TSTART;
      S_TSTART: state_nxt = S_TDIV;
      S_TDIV:   if (dv_done) state_nxt = S_AX;
      S_AX: begin
        if (ad_r[ax_r] != '0) begin
          state_nxt = S_PMUL;
        end else if (ax_r == 2'd2) begin
          state_nxt = S_RDJ;
        end
      end
      S_PMUL:   if (k_r == 2'd2) state_nxt = S_MSTART;
      S_MSTART: state_nxt = S_MDIV;
      S_MDIV: begin
        if (dv_done) begin
          state_nxt = (ax_r == 2'd2) ? S_RDJ : S_AX;
        end
      end
      S_EMIT: begin
        if (emit_ok) begin
          state_nxt = last_i ? S_IDLE : S_RDI;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = AW'(q_job.n - 1'b1);
    ram_raddr = i_r[AW-1:0];
    sq_start  = 1'b0;
    dv_start  = 1'b0;
    dv_num    = {s_r, {(DIV_NUM_W-T_W){1'b0}}};
    dv_den    = rr_r;
    dv_iters  = DIV_CNT_W'(T_W);
    unique case (state_r)
      S_POP: begin
        q_pop  = 1'b1;
        ram_we = q_job.keep;
      end
      S_RDJ:    ram_raddr = j_r[AW-1:0];
      S_CHK:    sq_start  = (r2_r != '0);
      S_TSTART: dv_start  = 1'b1;
      S_MSTART: begin
        dv_start = 1'b1;
        dv_num   = p_r;
        dv_den   = DIV_DEN_W'(r_r);
        dv_iters = DIV_CNT_W'(DIV_NUM_W);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_EMIT && emit_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_POP: begin
        n_r       <= q_job.n;
        set_ovf_r <= q_job.ovf;
        i_r       <= '0;
      end
      S_GM: begin
        xi_r   <= ram_rdata.x;
        yi_r   <= ram_rdata.y;
        zi_r   <= ram_rdata.z;
        gm_r   <= gravity * ram_rdata.mass;
        sum_r  <= '{default: '0};
        clip_r <= 1'b0;
        j_r    <= '0;
      end
      S_RDJ: begin
        if (j_r != n_r) begin
          j_r <= j_r + 1'b1;
        end
      end
      S_DIFF: begin
        ad_r[0]  <= dx[30] ? 31'(-dx) : dx;
        ad_r[1]  <= dy[30] ? 31'(-dy) : dy;
        ad_r[2]  <= dz[30] ? 31'(-dz) : dz;
        neg_r[0] <= dx[30];
        neg_r[1] <= dy[30];
        neg_r[2] <= dz[30];
        mj_r     <= ram_rdata.mass;
        r2_r     <= '0;
        ax_r     <= '0;
      end
      S_SQ: begin
        r2_r <= r2_r + R2_W'(ad_r[ax_r] * ad_r[ax_r]);
        ax_r <= ax_r + 1'b1;
      end
      S_SQRT:   if (sq_done) r_r <= sq_root;
      S_RR:     rr_r  <= DIV_DEN_W'(r_r * r_r);
      S_S0:     plo_r <= gm_r[31:0] * mj_r;
      S_S1:     phi_r <= gm_r[63:32] * mj_r;
      S_S2:     s_r   <= T_W'(({phi_r, 32'b0} + {32'b0, plo_r}) >> 24);
      S_TDIV: begin
        if (dv_done) begin
          t_r  <= dv_quo[T_W-1:0];
          ax_r <= '0;
        end
      end
      S_AX: begin
        p_r <= '0;
        k_r <= '0;
        if (ad_r[ax_r] == '0 && ax_r != 2'd2) begin
          ax_r <= ax_r + 1'b1;
        end
      end
      S_PMUL: begin
        p_r <= p_r + cterm;
        k_r <= k_r + 1'b1;
      end
      S_MDIV: begin
        if (dv_done) begin
          sum_r[ax_r] <= sum_r[ax_r] + term;
          clip_r      <= clip_r || mclip;
          if (ax_r != 2'd2) begin
            ax_r <= ax_r + 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (emit_ok) begin
          out_res_r.idx  <= IDX_W'(i_r);
          out_res_r.fx   <= cx.v;
          out_res_r.fy   <= cy.v;
          out_res_r.fz   <= three_axes ? cz.v : '0;
          out_res_r.sat  <= clip_r || cx.clip || cy.clip || (three_axes && cz.clip);
          out_res_r.ovf  <= set_ovf_r;
          out_res_r.last <= last_i;
          i_r            <= i_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/nbody_gravity_force.sv
// ---------------------------------------------------------------------------
// nbody_gravity_force - direct-sum gravitational force engine
// Loads a set of bodies and returns the net force on each of them.
// ---------------------------------------------------------------------------
// Usage. Each input beat carries one body: position and mass in in_tdata,
// with in_tlast marking the final body of the set. Bodies beyond the store
// capacity are dropped and reported through the overflow flag of the
// results. The beat carrying in_tlast starts the computation; the block
// then returns one beat per stored body, in load order, with out_tlast on
// the final one. Configuration is written through cfg_we, cfg_index and
// cfg_data while the block is idle.
// Operation. A load beat that does not close a set is queued and then
// written to the store. The forces are computed pair by pair on one
// iterative square-root unit and one shared bit-serial divider: a pair
// needs one 72-bit division plus one 103-bit division per non-zero axis
// separation. The first force appears after the work for body 0 is
// finished. Reset clears the set and restores G to 1 and three-axis mode;
// the body store needs no clearing. If the receiver stalls, the finished
// force waits in the output register and the sequencer pauses once its
// next force is ready; load beats are still queued until the short queue
// fills, then in_tready falls.
// ---------------------------------------------------------------------------
`default_nettype none

module nbody_gravity_force #(
  parameter int MAX_BODIES = nbgf_pkg::MAX_BODIES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Configuration write port
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  // Body load stream
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // pos_x, pos_y, pos_z, body_mass, zero pad
  input  wire logic         in_tlast,   // last_body
  // Force result stream
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic      [151:0] out_tdata,  // body_index, force_x, force_y, force_z, pad
  output logic      [1:0]   out_tuser,  // saturated, overflowed
  output logic              out_tlast   // last_force
);

  import nbgf_pkg::*;

  logic [31:0] gravity_r;
  logic        three_axes_r;

  // Configuration registers: unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r    <= 32'd1;
      three_axes_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_GRAVITY: gravity_r    <= cfg_data;
        REG_AXES:    three_axes_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  body_t   in_body;
  job_t    q_in, q_out;
  logic    q_push, q_full, q_pop, q_empty;
  result_t res;

  assign in_body.x    = in_tdata[29:0];
  assign in_body.y    = in_tdata[59:30];
  assign in_body.z    = in_tdata[89:60];
  assign in_body.mass = in_tdata[121:90];

  // The front end classifies each beat; the queue decouples it from the
  // sequencer and takes beats while the back end works, until it fills.
  nbgf_front #(.MAX_BODIES(MAX_BODIES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .three_axes (three_axes_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_body    (in_body),
    .in_last    (in_tlast),
    .q_push     (q_push),
    .q_job      (q_in),
    .q_full     (q_full)
  );

  nbgf_fifo #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  nbgf_back #(.MAX_BODIES(MAX_BODIES)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .gravity     (gravity_r),
    .three_axes  (three_axes_r),
    .q_empty     (q_empty),
    .q_job       (q_out),
    .q_pop       (q_pop),
    .out_valid_r (out_tvalid),
    .out_ready   (out_tready),
    .out_res_r   (res)
  );

  assign out_tdata = {2'b00, res.fz, res.fy, res.fx, res.idx};
  assign out_tuser = {res.ovf, res.sat};
  assign out_tlast = res.last;

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench - self-checking bench for the gravity force engine
// Streams sets of bodies into nbody_gravity_force under a range of gravity
// constants and axis modes, predicts every net force and compares each
// returned beat field by field, with random idling on both streams.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

import nbgf_pkg::*;

// Expected force for one stored body, fields at the block's widths.
typedef struct {
  logic [5:0]  idx;
  logic [47:0] fx;
  logic [47:0] fy;
  logic [47:0] fz;
  logic        sat;
  logic        ovf;
  logic        last;
} force_rec_t;

// Keeps a copy of the body store and the register state, works out the net
// forces when a set closes and checks the beats that come back.
class force_board;
  localparam longint unsigned TERM_CAP = 64'h00FF_FFFF_FFFF_FFFF;
  localparam longint OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint OUT_MIN = -64'sh0000_8000_0000_0000;

  bit [31:0]        grav;
  bit               axes3;
  int               count;
  bit               dropped;
  longint           bx [32];
  longint           by [32];
  longint           bz [32];
  longint unsigned  bm [32];
  force_rec_t       pending[$];
  int               errors;
  int               forces_seen;
  int               saturations;
  int               overflow_sets;

  function new();
    grav = 1;
    axes3 = 1'b1;
    count = 0;
    dropped = 1'b0;
    errors = 0;
    forces_seen = 0;
    saturations = 0;
    overflow_sets = 0;
  endfunction

  // Floor square root, bit by bit.
  static function longint unsigned int_root(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // One axis contribution: t*|d|/r, clipped to 56 bits, with the sign of d.
  static function longint axis_term(bit [127:0] t, longint d, longint unsigned r,
                                    ref bit clip);
    bit [127:0] ad, m;
    ad = (d < 0) ? 128'(-d) : 128'(d);
    m = (t * ad) / r;
    if (m > TERM_CAP) begin
      clip = 1'b1;
      m = TERM_CAP;
    end
    return (d < 0) ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  static function logic [47:0] clamp48(longint s, ref bit clip);
    if (s > OUT_MAX) begin
      s = OUT_MAX;
      clip = 1'b1;
    end
    if (s < OUT_MIN) begin
      s = OUT_MIN;
      clip = 1'b1;
    end
    return s[47:0];
  endfunction

  // Notes one accepted load beat; a closing beat queues the set's forces.
  function void note_body(logic [29:0] x, logic [29:0] y, logic [29:0] z,
                          logic [31:0] mass, logic last);
    int i, j;
    longint sx, sy, sz, dx, dy, dz;
    longint unsigned gm, r2, r;
    bit [127:0] s, t;
    bit clip;
    force_rec_t rec;
    if (count < 32) begin
      bx[count] = longint'($signed(x));
      by[count] = longint'($signed(y));
      bz[count] = axes3 ? longint'($signed(z)) : 0;
      bm[count] = mass;
      count++;
    end else begin
      dropped = 1'b1;
    end
    if (!last) return;
    if (dropped) overflow_sets++;
    for (i = 0; i < count; i++) begin
      sx = 0;
      sy = 0;
      sz = 0;
      clip = 1'b0;
      gm = longint'(grav) * bm[i];
      for (j = 0; j < count; j++) begin
        if (j == i) continue;
        dx = bx[j] - bx[i];
        dy = by[j] - by[i];
        dz = axes3 ? bz[j] - bz[i] : 0;
        r2 = dx * dx + dy * dy + dz * dz;
        // Coincident bodies exert nothing on each other.
        if (r2 == 0) continue;
        r = int_root(r2);
        s = (128'(gm) * 128'(bm[j])) >> 24;
        t = s / 128'(r * r);
        sx += axis_term(t, dx, r, clip);
        sy += axis_term(t, dy, r, clip);
        sz += axis_term(t, dz, r, clip);
      end
      rec.idx  = i[5:0];
      rec.fx   = clamp48(sx, clip);
      rec.fy   = clamp48(sy, clip);
      rec.fz   = axes3 ? clamp48(sz, clip) : 48'd0;
      rec.sat  = clip;
      rec.ovf  = dropped;
      rec.last = (i + 1 == count);
      pending.push_back(rec);
    end
    count = 0;
    dropped = 1'b0;
  endfunction

  // Compares one returned force beat with the oldest expectation.
  function void check_force(force_rec_t got);
    force_rec_t exp_f;
    forces_seen++;
    if (pending.size() == 0) begin
      $error("force beat for body %0d with nothing expected", got.idx);
      errors++;
      return;
    end
    exp_f = pending.pop_front();
    if (exp_f.sat) saturations++;
    if (got.idx !== exp_f.idx) begin
      $error("body_index: expected %0d, got %0d", exp_f.idx, got.idx);
      errors++;
    end
    if (got.fx !== exp_f.fx) begin
      $error("force_x: expected %0d, got %0d", $signed(exp_f.fx), $signed(got.fx));
      errors++;
    end
    if (got.fy !== exp_f.fy) begin
      $error("force_y: expected %0d, got %0d", $signed(exp_f.fy), $signed(got.fy));
      errors++;
    end
    if (got.fz !== exp_f.fz) begin
      $error("force_z: expected %0d, got %0d", $signed(exp_f.fz), $signed(got.fz));
      errors++;
    end
    if (got.sat !== exp_f.sat) begin
      $error("saturated: expected %0b, got %0b", exp_f.sat, got.sat);
      errors++;
    end
    if (got.ovf !== exp_f.ovf) begin
      $error("overflowed: expected %0b, got %0b", exp_f.ovf, got.ovf);
      errors++;
    end
    if (got.last !== exp_f.last) begin
      $error("last_force: expected %0b, got %0b", exp_f.last, got.last);
      errors++;
    end
  endfunction
endclass

module testbench;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [0:0]   cfg_index;
  logic [31:0]  cfg_data;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // pos_x, pos_y, pos_z, body_mass, zero pad
  logic         in_tlast;   // last_body
  logic         out_tvalid;
  logic         out_tready;
  logic [151:0] out_tdata;  // body_index, force_x, force_y, force_z, pad
  logic [1:0]   out_tuser;  // saturated, overflowed
  logic         out_tlast;  // last_force

  force_board board;
  int bodies_sent;
  int sets_sent;
  bit quiet;        // when set, the sender puts no gaps between beats
  bit out_hold;     // when set, the receiver stays ready throughout

  nbody_gravity_force dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Register writes go in only while the block is idle.
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_GRAVITY) board.grav = value;
    else board.axes3 = value[0];
  endtask

  // Sends one body beat and waits until the block takes it. Called at a
  // falling edge and returns at a falling edge.
  task automatic send_body(logic [29:0] x, logic [29:0] y, logic [29:0] z,
                           logic [31:0] mass, logic last);
    int gap;
    gap = quiet ? 0 : gap_len();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {6'd0, mass, z, y, x};
    in_tlast = last;
    do @(posedge clk); while (!in_tready);
    board.note_body(x, y, z, mass, last);
    bodies_sent++;
    if (last) sets_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Waits until every expected force has arrived and the engine has settled.
  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Random position: either a tight cluster, where forces are large, or the
  // full signed range so that every bit of the field toggles.
  function automatic logic [29:0] pick_pos(logic [29:0] centre, bit wide);
    if (wide) return 30'($urandom());
    return centre + 30'($signed($urandom_range(0, 8191)) - 4096);
  endfunction

  function automatic logic [31:0] pick_mass();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 255);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  // A random set of n bodies; sets larger than 32 exercise the dropped loads.
  task automatic send_set(int n);
    logic [29:0] cx, cy, cz;
    bit wide;
    wide = ($urandom_range(0, 2) == 0);
    cx = 30'(int'($urandom_range(0, 2**28)) - 2**27);
    cy = 30'(int'($urandom_range(0, 2**28)) - 2**27);
    cz = 30'(int'($urandom_range(0, 2**28)) - 2**27);
    quiet = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < n; k++)
      send_body(pick_pos(cx, wide), pick_pos(cy, wide), pick_pos(cz, wide),
                pick_mass(), k == n - 1);
    quiet = 1'b0;
  endtask

  // Receiver: random stalls, short mostly, with some long ones.
  initial begin
    out_tready = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (out_hold) begin
        out_tready = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_tready = 1'b0;
        repeat (gap_len() + 1) @(negedge clk);
        out_tready = 1'b1;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end
    end
  end

  // Every force beat is checked at the edge that accepts it.
  always @(posedge clk) begin
    force_rec_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.idx  = out_tdata[5:0];
      got.fx   = out_tdata[53:6];
      got.fy   = out_tdata[101:54];
      got.fz   = out_tdata[149:102];
      got.sat  = out_tuser[0];
      got.ovf  = out_tuser[1];
      got.last = out_tlast;
      board.check_force(got);
    end
  end

  // Stimulus.
  initial begin
    logic [29:0] pmax, pmin;
    int n;
    board = new();
    bodies_sent = 0;
    sets_sent = 0;
    quiet = 1'b0;
    out_hold = 1'b0;
    pmax = 30'h1FFF_FFFF;
    pmin = 30'h2000_0000;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_GRAVITY;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // A lone body feels nothing.
    send_body(30'd5, -30'sd7, 30'd9, 32'd1000, 1'b1);
    // Two coincident bodies skip each other; only the massive one feels the third.
    send_body(30'd100, 30'd200, 30'd300, 32'hFFFF_FFFF, 1'b0);
    send_body(30'd100, 30'd200, 30'd300, 32'd0, 1'b0);
    send_body(30'd104, 30'd197, 30'd300, 32'h0001_0000, 1'b1);
    drain();

    // Largest G with heavy bodies: neighbours clip per term and clamp the sum,
    // the far corners stay in range.
    write_reg(REG_GRAVITY, 32'hFFFF_FFFF);
    send_body(30'd0, 30'd0, 30'd0, 32'hFFFF_FFFF, 1'b0);
    send_body(30'd1, 30'd0, 30'd0, 32'hFFFF_FFFF, 1'b1);
    send_body(pmax, pmax, pmax, 32'hFFFF_FFFF, 1'b0);
    send_body(pmin, pmin, pmin, 32'hFFFF_FFFF, 1'b1);
    drain();

    // Two-axis mode: bodies apart only in z count as coincident.
    write_reg(REG_AXES, 32'd0);
    write_reg(REG_GRAVITY, 32'h0100_0000);
    send_body(30'd10, 30'd10, pmin, 32'h00FF_FFFF, 1'b0);
    send_body(30'd10, 30'd10, pmax, 32'h00FF_FFFF, 1'b0);
    send_body(30'd12, 30'd7, 30'd0, 32'h00FF_FFFF, 1'b1);
    drain();

    // Zero G gives zero forces everywhere.
    write_reg(REG_GRAVITY, 32'd0);
    write_reg(REG_AXES, 32'd1);
    send_body(pmin, 30'd0, pmax, 32'hFFFF_FFFF, 1'b0);
    send_body(pmax, 30'd3, pmin, 32'hFFFF_FFFF, 1'b1);
    drain();

    // Random phases over several register settings. Sets are kept small as
    // the cost grows with the square of their size.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: write_reg(REG_GRAVITY, 32'd1);
        1: write_reg(REG_GRAVITY, 32'hFFFF_FFFF);
        2: write_reg(REG_GRAVITY, 32'd0);
        default: write_reg(REG_GRAVITY, $urandom());
      endcase
      write_reg(REG_AXES, 32'($urandom_range(0, 1)));
      out_hold = (phase == 5);
      // One set beyond the store's capacity, in the middle of the run.
      if (phase == 4) send_set(34);
      while (bodies_sent < 30 + (phase + 1) * 44) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
        send_set(n);
      end
      drain();
    end

    $display("Covered %0d sets and %0d bodies; %0d forces checked, %0d saturated,",
             sets_sent, bodies_sent, board.forces_seen, board.saturations);
    $display("%0d sets with dropped loads, in both axis modes and several G values.",
             board.overflow_sets);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("nbody_gravity_force test passed");
    else
      $display("nbody_gravity_force test failed");
    $finish;
  end

  // Watchdog, well beyond the slowest correct run.
  initial begin
    #20000000;
    $display("nbody_gravity_force test failed");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/nbgf_pkg.sv
hw/rtl/nbgf_ram.sv
hw/rtl/nbgf_fifo.sv
hw/rtl/nbgf_front.sv
hw/rtl/nbgf_sqrt.sv
hw/rtl/nbgf_div.sv
hw/rtl/nbgf_back.sv
hw/rtl/nbody_gravity_force.sv
tb/testbench.sv
